// File: rtl/tdcc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tdcc_pkg: shared types and constants for the time-of-day colour clock
// Field widths, operation codes, arithmetic constants and the default
// hour colour table.
// ----------------------------------------------------------------------------
package tdcc_pkg;

	// field widths
	localparam int OP_W      = 2;
	localparam int ELAPSED_W = 16;
	localparam int HOUR_W    = 5;
	localparam int MINUTE_W  = 6;
	localparam int DAYS_W    = 32;
	localparam int INDEX_W   = 5;
	localparam int CH_W      = 8;
	localparam int NUM_CH    = 3;
	localparam int COLOR_W   = CH_W * NUM_CH;
	localparam int ACC_W     = 24;
	localparam int DAY_LEN_W = 16;

	// configuration port
	localparam int PADDR_W = 2;
	localparam int PDATA_W = 32;
	localparam logic [PADDR_W-1:0] REG_DAY_LENGTH = '0;

	// time constants
	localparam int TABLE_ENTRIES     = 25;
	localparam int ELAPSED_FRAC_BITS = 8;
	localparam int MINUTES_PER_HOUR  = 60;
	localparam int HOURS_PER_DAY     = 24;
	localparam int DAY_SCALE         = 100;
	localparam int RESET_DAY_LENGTH  = 900;
	localparam int RESET_HOUR        = 12;

	// minute length in whole units: day_length * 100 / 1440, at most 4551
	localparam int THRESH_W     = 13;
	localparam int RESET_THRESH = RESET_DAY_LENGTH * DAY_SCALE / HOURS_PER_DAY
		/ MINUTES_PER_HOUR;
	// floor(z / 9) = (z * RECIP9) >> RECIP9_SHIFT, exact for z < 65536
	localparam int RECIP9       = 58255;
	localparam int RECIP9_SHIFT = 19;
	// floor(x / 60) = (x * RECIP60) >> RECIP60_SHIFT, exact for x < 23840
	localparam int RECIP60       = 17477;
	localparam int RECIP60_SHIFT = 20;
	localparam int RECIP60_W     = 15;
	// magnitude of (hi - lo) * minute, at most 255 * 59
	localparam int MAG_W = 14;

	typedef enum logic [OP_W-1:0] {
		OP_TICK        = 2'd0,
		OP_SET_TIME    = 2'd1,
		OP_WRITE_ENTRY = 2'd2
	} op_t;

	// default day table: red 23..16, green 15..8, blue 7..0
	localparam logic [COLOR_W-1:0] DEFAULT_COLORS [TABLE_ENTRIES] = '{
		24'h4E5CAF, 24'h5964A9, 24'h606BAE, 24'h6A76BA, 24'h6E76BA,
		24'h7883C6, 24'h98A3E8, 24'hB6BEEE, 24'hD6DAF3, 24'hF4F5FB,
		24'hFFFFFF, 24'hFFFFFF, 24'hF7F8EC, 24'hF7F8E7, 24'hEFF2E1,
		24'hEDEDD2, 24'hE8ECC8, 24'hE8E1BE, 24'hE4C47E, 24'hE5A67E,
		24'hE59E96, 24'h7D7CC8, 24'h766FD8, 24'h645CBE, 24'h525CAF
	};

endpackage
`default_nettype wire

// File: rtl/tdcc_item_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tdcc_item_if: input word channel
// Valid/ready handshake carrying one operation word (tick, set time or
// colour table write).
// ----------------------------------------------------------------------------
interface tdcc_item_if import tdcc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [OP_W-1:0]      operation;
	logic [ELAPSED_W-1:0] elapsed;
	logic [HOUR_W-1:0]    set_hour;
	logic [MINUTE_W-1:0]  set_minute;
	logic [DAYS_W-1:0]    set_days;
	logic [INDEX_W-1:0]   entry_index;
	logic [CH_W-1:0]      entry_red;
	logic [CH_W-1:0]      entry_green;
	logic [CH_W-1:0]      entry_blue;

	modport source (
		output valid, operation, elapsed, set_hour, set_minute, set_days,
		       entry_index, entry_red, entry_green, entry_blue,
		input  ready
	);

	modport sink (
		input  valid, operation, elapsed, set_hour, set_minute, set_days,
		       entry_index, entry_red, entry_green, entry_blue,
		output ready
	);
endinterface
`default_nettype wire

// File: rtl/tdcc_tint_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tdcc_tint_if: result word channel
// Valid/ready handshake carrying the tint and the time of day.
// ----------------------------------------------------------------------------
interface tdcc_tint_if import tdcc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CH_W-1:0]     tint_red;
	logic [CH_W-1:0]     tint_green;
	logic [CH_W-1:0]     tint_blue;
	logic [HOUR_W-1:0]   hour_now;
	logic [MINUTE_W-1:0] minute_now;
	logic [DAYS_W-1:0]   days_passed;

	modport source (
		output valid, tint_red, tint_green, tint_blue, hour_now, minute_now,
		       days_passed,
		input  ready
	);

	modport sink (
		input  valid, tint_red, tint_green, tint_blue, hour_now, minute_now,
		       days_passed,
		output ready
	);
endinterface
`default_nettype wire

// File: rtl/time_of_day_color_clock.sv
`default_nettype none
// ----------------------------------------------------------------------------
// time_of_day_color_clock: simulated clock with interpolated ambient tint
// Keeps minutes, hours and days, advanced by tick words, and answers every
// word with the tint blended between the colours of this hour and the next.
// ----------------------------------------------------------------------------
// One word is accepted per clock while the output is not stalled, and every
// word gives exactly one result word: the colour table is read into a
// register at the accepting edge (two read ports, at the hour and the hour
// after), then the colour difference is multiplied by the minute, the
// reciprocal multiply divides by sixty, and the output register is loaded.
// The time of day is updated at the edge that accepts the word, so a word may
// follow in the next cycle. The colour table comes out of reset holding the
// default day table at once; no clearing pass is needed. day_length is set
// over the APB port at byte address 0 and takes effect for the next word.
// ----------------------------------------------------------------------------
module time_of_day_color_clock import tdcc_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	tdcc_item_if.sink               item_in,
	tdcc_tint_if.source             tint_out
);

	localparam int SHIFT_W = THRESH_W + ELAPSED_FRAC_BITS;
	localparam int CMP_W   = (SHIFT_W > ACC_W) ? SHIFT_W : ACC_W;

	// ------------------------------------------------------------------
	// configuration
	// ------------------------------------------------------------------
	logic [DAY_LEN_W-1:0]  day_length_q;
	logic [THRESH_W-1:0]   thresh_q;
	logic                  cfg_wr;
	logic [DAY_LEN_W+2:0]  cfg_times5;
	logic [DAY_LEN_W-1:0]  cfg_div8;
	logic [2*DAY_LEN_W-1:0] cfg_prod;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_DAY_LENGTH);

	// minute length = floor(floor(day_length * 5 / 8) / 9)
	assign cfg_times5 = ({3'b000, pwdata[DAY_LEN_W-1:0]} << 2)
		+ {3'b000, pwdata[DAY_LEN_W-1:0]};
	assign cfg_div8   = cfg_times5[DAY_LEN_W+2:3];
	assign cfg_prod   = cfg_div8 * DAY_LEN_W'(RECIP9);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			day_length_q <= DAY_LEN_W'(RESET_DAY_LENGTH);
			thresh_q     <= THRESH_W'(RESET_THRESH);
		end else if (cfg_wr) begin
			day_length_q <= pwdata[DAY_LEN_W-1:0];
			thresh_q     <= cfg_prod[RECIP9_SHIFT +: THRESH_W];
		end
	end

	assign prdata = (paddr == REG_DAY_LENGTH) ?
		{{(PDATA_W-DAY_LEN_W){1'b0}}, day_length_q} : '0;

	// ------------------------------------------------------------------
	// pipeline flow: each stage moves on when the one below has room
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, out_valid_q;
	logic take1, take2, take3, free1, free2, free3, out_free;
	logic accept;

	assign out_free = !out_valid_q || tint_out.ready;
	assign take3    = v_s3 && out_free;
	assign free3    = !v_s3 || take3;
	assign take2    = v_s2 && free3;
	assign free2    = !v_s2 || take2;
	assign take1    = v_s1 && free2;
	assign free1    = !v_s1 || take1;

	assign item_in.ready = free1;
	assign accept        = item_in.valid && free1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept)
				v_s1 <= 1'b1;
			else if (take1)
				v_s1 <= 1'b0;
			if (take1)
				v_s2 <= 1'b1;
			else if (take2)
				v_s2 <= 1'b0;
			if (take2)
				v_s3 <= 1'b1;
			else if (take3)
				v_s3 <= 1'b0;
			if (take3)
				out_valid_q <= 1'b1;
			else if (tint_out.ready)
				out_valid_q <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// time of day, updated at the accepting edge
	// ------------------------------------------------------------------
	logic [ACC_W-1:0]    acc_q, acc_n;
	logic [MINUTE_W-1:0] minute_count_q, minute_n;
	logic [HOUR_W-1:0]   hour_count_q, hour_n;
	logic [DAYS_W-1:0]   day_count_q, days_n;
	logic [ACC_W:0]      acc_sum;
	logic [ACC_W-1:0]    acc_sat;
	logic [CMP_W-1:0]    thresh_cmp;
	logic                minute_up;
	logic                wr_en;
	logic [COLOR_W-1:0]  wr_data;

	assign acc_sum    = {1'b0, acc_q} + {{(ACC_W+1-ELAPSED_W){1'b0}}, item_in.elapsed};
	assign acc_sat    = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
	assign thresh_cmp = CMP_W'(thresh_q) << ELAPSED_FRAC_BITS;
	assign minute_up  = CMP_W'(acc_sat) > thresh_cmp;
	assign wr_data    = {item_in.entry_red, item_in.entry_green, item_in.entry_blue};

	always_comb begin
		acc_n    = acc_q;
		minute_n = minute_count_q;
		hour_n   = hour_count_q;
		days_n   = day_count_q;
		wr_en    = 1'b0;
		case (item_in.operation)
			OP_TICK: begin
				if (day_length_q != '0) begin
					acc_n = acc_sat;
					if (minute_up) begin
						acc_n = '0;
						if (minute_count_q == MINUTE_W'(MINUTES_PER_HOUR - 1)) begin
							minute_n = '0;
							if (hour_count_q == HOUR_W'(HOURS_PER_DAY - 1)) begin
								hour_n = '0;
								days_n = day_count_q + DAYS_W'(1);
							end else begin
								hour_n = hour_count_q + HOUR_W'(1);
							end
						end else begin
							minute_n = minute_count_q + MINUTE_W'(1);
						end
					end
				end
			end
			OP_SET_TIME: begin
				// out-of-range hour wraps once, out-of-range minute clamps
				hour_n = (item_in.set_hour >= HOUR_W'(HOURS_PER_DAY)) ?
					item_in.set_hour - HOUR_W'(HOURS_PER_DAY) : item_in.set_hour;
				minute_n = (item_in.set_minute >= MINUTE_W'(MINUTES_PER_HOUR)) ?
					MINUTE_W'(MINUTES_PER_HOUR - 1) : item_in.set_minute;
				days_n = item_in.set_days;
				acc_n  = '0;
			end
			OP_WRITE_ENTRY: begin
				wr_en = accept && (item_in.entry_index < INDEX_W'(TABLE_ENTRIES));
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q          <= '0;
			minute_count_q <= '0;
			hour_count_q   <= HOUR_W'(RESET_HOUR);
			day_count_q    <= '0;
		end else if (accept) begin
			acc_q          <= acc_n;
			minute_count_q <= minute_n;
			hour_count_q   <= hour_n;
			day_count_q    <= days_n;
		end
	end

	// ------------------------------------------------------------------
	// colour table: one write port, two registered read ports
	// entries never written read as the default table
	// ------------------------------------------------------------------
	logic [COLOR_W-1:0]       color_mem [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] written_q;
	logic [INDEX_W-1:0]       addr_lo, addr_hi;

	assign addr_lo = hour_n;
	assign addr_hi = hour_n + INDEX_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			written_q <= '0;
		else if (wr_en)
			written_q[item_in.entry_index] <= 1'b1;
	end

	logic [COLOR_W-1:0]  rd_lo_s1, rd_hi_s1, wdata_s1;
	logic                fwd_lo_s1, fwd_hi_s1, valid_lo_s1, valid_hi_s1;
	logic [INDEX_W-1:0]  addr_lo_s1, addr_hi_s1;
	logic [MINUTE_W-1:0] minute_s1;
	logic [HOUR_W-1:0]   hour_s1;
	logic [DAYS_W-1:0]   days_s1;

	always_ff @(posedge clk) begin
		if (wr_en)
			color_mem[item_in.entry_index] <= wr_data;
		if (accept) begin
			rd_lo_s1    <= color_mem[addr_lo];
			rd_hi_s1    <= color_mem[addr_hi];
			// a write in the same cycle is forwarded past the array
			fwd_lo_s1   <= wr_en && (item_in.entry_index == addr_lo);
			fwd_hi_s1   <= wr_en && (item_in.entry_index == addr_hi);
			valid_lo_s1 <= written_q[addr_lo];
			valid_hi_s1 <= written_q[addr_hi];
			wdata_s1    <= wr_data;
			addr_lo_s1  <= addr_lo;
			addr_hi_s1  <= addr_hi;
			minute_s1   <= minute_n;
			hour_s1     <= hour_n;
			days_s1     <= days_n;
		end
	end

	// ------------------------------------------------------------------
	// stage 1: resolve endpoints, difference times minute
	// ------------------------------------------------------------------
	logic [COLOR_W-1:0]  lo_word, hi_word;

	assign lo_word = fwd_lo_s1 ? wdata_s1 :
		(valid_lo_s1 ? rd_lo_s1 : DEFAULT_COLORS[addr_lo_s1]);
	assign hi_word = fwd_hi_s1 ? wdata_s1 :
		(valid_hi_s1 ? rd_hi_s1 : DEFAULT_COLORS[addr_hi_s1]);

	logic [MAG_W-1:0]    mag_s2 [NUM_CH];
	logic                neg_s2 [NUM_CH];
	logic [CH_W-1:0]     lo_s2  [NUM_CH];
	logic [CH_W-1:0]     q_s3   [NUM_CH];
	logic                neg_s3 [NUM_CH];
	logic [CH_W-1:0]     lo_s3  [NUM_CH];
	logic [CH_W-1:0]     tint_q [NUM_CH];

	logic [MINUTE_W-1:0] minute_s2, minute_s3, out_minute_q;
	logic [HOUR_W-1:0]   hour_s2, hour_s3, out_hour_q;
	logic [DAYS_W-1:0]   days_s2, days_s3, out_days_q;

	// lane 0 red, lane 1 green, lane 2 blue
	for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
		logic [CH_W-1:0]                  lo_ch, hi_ch;
		logic signed [CH_W:0]             diff;
		logic signed [CH_W+MINUTE_W+1:0]  prod;
		logic [CH_W+MINUTE_W+1:0]         prod_abs;
		logic [MAG_W+RECIP60_W-1:0]       quot;

		assign lo_ch    = lo_word[CH_W*(NUM_CH-1-c) +: CH_W];
		assign hi_ch    = hi_word[CH_W*(NUM_CH-1-c) +: CH_W];
		assign diff     = $signed({1'b0, hi_ch}) - $signed({1'b0, lo_ch});
		assign prod     = diff * $signed({1'b0, minute_s1});
		assign prod_abs = prod[CH_W+MINUTE_W+1] ? -prod : prod;

		// stage 2: divide the magnitude by sixty through the reciprocal
		assign quot = mag_s2[c] * RECIP60_W'(RECIP60);

		always_ff @(posedge clk) begin
			if (take1) begin
				mag_s2[c] <= prod_abs[MAG_W-1:0];
				neg_s2[c] <= prod[CH_W+MINUTE_W+1];
				lo_s2[c]  <= lo_ch;
			end
			if (take2) begin
				q_s3[c]   <= quot[RECIP60_SHIFT +: CH_W];
				neg_s3[c] <= neg_s2[c];
				lo_s3[c]  <= lo_s2[c];
			end
			// stage 3: quotient rounded toward zero, added back to the base
			if (take3)
				tint_q[c] <= neg_s3[c] ? lo_s3[c] - q_s3[c] : lo_s3[c] + q_s3[c];
		end
	end

	// time of day travels alongside the colour lanes
	always_ff @(posedge clk) begin
		if (take1) begin
			minute_s2 <= minute_s1;
			hour_s2   <= hour_s1;
			days_s2   <= days_s1;
		end
		if (take2) begin
			minute_s3 <= minute_s2;
			hour_s3   <= hour_s2;
			days_s3   <= days_s2;
		end
		if (take3) begin
			out_minute_q <= minute_s3;
			out_hour_q   <= hour_s3;
			out_days_q   <= days_s3;
		end
	end

	// ------------------------------------------------------------------
	// result word
	// ------------------------------------------------------------------
	assign tint_out.valid       = out_valid_q;
	assign tint_out.tint_red    = tint_q[0];
	assign tint_out.tint_green  = tint_q[1];
	assign tint_out.tint_blue   = tint_q[2];
	assign tint_out.hour_now    = out_hour_q;
	assign tint_out.minute_now  = out_minute_q;
	assign tint_out.days_passed = out_days_q;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	a_time_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (minute_count_q < MINUTE_W'(MINUTES_PER_HOUR))
			&& (hour_count_q < HOUR_W'(HOURS_PER_DAY)))
		else $error("time of day out of range after a word");

	a_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (item_in.operation == OP_TICK) && (day_length_q == '0))
			|=> ($stable(acc_q) && $stable(minute_count_q) && $stable(hour_count_q)))
		else $error("tick changed the time while day_length is zero");

	a_entry_marked: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> written_q[$past(item_in.entry_index)])
		else $error("written table entry not marked");

	a_stage_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> v_s1)
		else $error("accepted word lost at the table read stage");

	a_result_flows: assert property (@(posedge clk) disable iff (!arst_n)
		take3 |=> out_valid_q)
		else $error("result word not presented after the last stage");

endmodule
`default_nettype wire

// File: tb/tb_time_of_day_color_clock.sv
// ----------------------------------------------------------------------------
// tb_time_of_day_color_clock: self-checking bench for the colour clock
// Drives tick, set-time and colour table words through the input channel,
// keeps its own copy of the clock and the colour table to work out the tint
// and time that each word should give, and checks every result word against
// it. day_length is rewritten over APB between phases, including zero and
// the largest value, while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_time_of_day_color_clock;
	import tdcc_pkg::*;

	localparam logic [OP_W-1:0] OP_SPARE = 2'd3;   // unused code, reports only
	localparam int ACC_FULL       = (1 << ACC_W) - 1;
	localparam int SETTLE_CYCLES  = 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_HOLD      = 64;
	localparam int PHASES         = 8;
	localparam int PHASE_WORDS    = 130;

	typedef struct packed {
		logic [OP_W-1:0]      operation;
		logic [ELAPSED_W-1:0] elapsed;
		logic [HOUR_W-1:0]    set_hour;
		logic [MINUTE_W-1:0]  set_minute;
		logic [DAYS_W-1:0]    set_days;
		logic [INDEX_W-1:0]   entry_index;
		logic [CH_W-1:0]      entry_red;
		logic [CH_W-1:0]      entry_green;
		logic [CH_W-1:0]      entry_blue;
	} clock_word_t;

	typedef struct packed {
		logic [CH_W-1:0]     red;
		logic [CH_W-1:0]     green;
		logic [CH_W-1:0]     blue;
		logic [HOUR_W-1:0]   hour;
		logic [MINUTE_W-1:0] minute;
		logic [DAYS_W-1:0]   days;
	} tint_word_t;

	typedef struct packed {
		clock_word_t word;
		logic        typed;
		tint_word_t  want;
	} script_row_t;

	localparam tint_word_t NO_TINT = '0;

	// directed words; a typed expectation is used where the set bit is high
	localparam int SCRIPT_ROWS = 23;
	localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
		// reset state: noon, noon colour
		'{'{OP_SPARE, 16'h0000, 5'd0, 6'd0, 32'h0, 5'd0, 8'h00, 8'h00, 8'h00}, 1'b1,
			'{8'hF7, 8'hF8, 8'hEC, 5'd12, 6'd0, 32'd0}},
		'{'{OP_TICK, 16'h0000, 5'd0, 6'd0, 32'h0, 5'd0, 8'h00, 8'h00, 8'h00}, 1'b1,
			'{8'hF7, 8'hF8, 8'hEC, 5'd12, 6'd0, 32'd0}},
		// sum equal to the minute length does not step
		'{'{OP_TICK, 16'h3E00, 5'd0, 6'd0, 32'h0, 5'd0, 8'h00, 8'h00, 8'h00}, 1'b1,
			'{8'hF7, 8'hF8, 8'hEC, 5'd12, 6'd0, 32'd0}},
		'{'{OP_TICK, 16'h0001, 5'd0, 6'd0, 32'h0, 5'd0, 8'h00, 8'h00, 8'h00}, 1'b0, NO_TINT},
		'{'{OP_TICK, 16'hFFFF, 5'd0, 6'd0, 32'h0, 5'd0, 8'h00, 8'h00, 8'h00}, 1'b0, NO_TINT},
		// last minute of the last day, then roll over everything
		'{'{OP_SET_TIME, 16'h0000, 5'd23, 6'd59, 32'hFFFF_FFFF, 5'd0, 8'h00, 8'h00, 8'h00},
			1'b0, NO_TINT},
		'{'{OP_TICK, 16'hFFFF, 5'd0, 6'd0, 32'h0, 5'd0, 8'h00, 8'h00, 8'h00}, 1'b1,
			'{8'h4E, 8'h5C, 8'hAF, 5'd0, 6'd0, 32'd0}},
		// hour and minute out of range
		'{'{OP_SET_TIME, 16'hFFFF, 5'd31, 6'd63, 32'h0, 5'd31, 8'hFF, 8'hFF, 8'hFF},
			1'b0, NO_TINT},
		'{'{OP_SET_TIME, 16'h0000, 5'd24, 6'd60, 32'h5555_AAAA, 5'd0, 8'h00, 8'h00, 8'h00},
			1'b0, NO_TINT},
		// table writes at both ends, and indexes past the table
		'{'{OP_WRITE_ENTRY, 16'h0000, 5'd0, 6'd0, 32'h0, 5'd0, 8'hFF, 8'hFF, 8'hFF},
			1'b0, NO_TINT},
		'{'{OP_WRITE_ENTRY, 16'h0000, 5'd0, 6'd0, 32'h0, 5'd24, 8'h00, 8'h00, 8'h00},
			1'b0, NO_TINT},
		'{'{OP_WRITE_ENTRY, 16'hFFFF, 5'd31, 6'd63, 32'hFFFF_FFFF, 5'd31, 8'h12, 8'h34, 8'h56},
			1'b0, NO_TINT},
		'{'{OP_WRITE_ENTRY, 16'h0000, 5'd0, 6'd0, 32'h0, 5'd25, 8'hAB, 8'hCD, 8'hEF},
			1'b0, NO_TINT},
		'{'{OP_SET_TIME, 16'h0000, 5'd23, 6'd30, 32'd1, 5'd0, 8'h00, 8'h00, 8'h00},
			1'b0, NO_TINT},
		// blend extremes in the last hour
		'{'{OP_WRITE_ENTRY, 16'h0000, 5'd0, 6'd0, 32'h0, 5'd23, 8'h00, 8'h00, 8'h00}, 1'b1,
			'{8'h00, 8'h00, 8'h00, 5'd23, 6'd30, 32'd1}},
		'{'{OP_WRITE_ENTRY, 16'h0000, 5'd0, 6'd0, 32'h0, 5'd24, 8'hFF, 8'hFF, 8'hFF}, 1'b1,
			'{8'h7F, 8'h7F, 8'h7F, 5'd23, 6'd30, 32'd1}},
		'{'{OP_SET_TIME, 16'h0000, 5'd23, 6'd59, 32'd7, 5'd0, 8'h00, 8'h00, 8'h00}, 1'b1,
			'{8'hFA, 8'hFA, 8'hFA, 5'd23, 6'd59, 32'd7}},
		'{'{OP_WRITE_ENTRY, 16'h0000, 5'd0, 6'd0, 32'h0, 5'd23, 8'hFF, 8'hFF, 8'hFF},
			1'b0, NO_TINT},
		// falling blend truncates toward zero
		'{'{OP_WRITE_ENTRY, 16'h0000, 5'd0, 6'd0, 32'h0, 5'd24, 8'h00, 8'h00, 8'h00}, 1'b1,
			'{8'h05, 8'h05, 8'h05, 5'd23, 6'd59, 32'd7}},
		'{'{OP_SET_TIME, 16'h0000, 5'd0, 6'd0, 32'd0, 5'd0, 8'h00, 8'h00, 8'h00}, 1'b1,
			'{8'hFF, 8'hFF, 8'hFF, 5'd0, 6'd0, 32'd0}},
		'{'{OP_WRITE_ENTRY, 16'h0000, 5'd0, 6'd0, 32'h0, 5'd16, 8'hAA, 8'h55, 8'hAA},
			1'b0, NO_TINT},
		'{'{OP_WRITE_ENTRY, 16'h0000, 5'd0, 6'd0, 32'h0, 5'd15, 8'h55, 8'hAA, 8'h55},
			1'b0, NO_TINT},
		'{'{OP_SET_TIME, 16'h0000, 5'd16, 6'd32, 32'h8000_0000, 5'd0, 8'h00, 8'h00, 8'h00},
			1'b0, NO_TINT}
	};

	logic                clk = 1'b0;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	tdcc_item_if item_if ();
	tdcc_tint_if tint_if ();

	time_of_day_color_clock uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.item_in  (item_if),
		.tint_out (tint_if)
	);

	always #2 clk = ~clk;

	// clock and colour table as the block should hold them
	int                 day_len_set;
	int                 clk_acc;
	int                 clk_minute;
	int                 clk_hour;
	logic [DAYS_W-1:0]  clk_days;
	logic [COLOR_W-1:0] clk_colours [TABLE_ENTRIES];

	tint_word_t tint_due [$];
	int         fault_count = 0;
	int         quiet_cycles = 0;
	int         send_idle_pct = 0;
	int         recv_idle_pct = 0;
	bit         long_hold_req = 1'b0;

	task automatic report_fault(input string msg);
		if (fault_count < 10)
			$display("%0t mismatch: %s", $time, msg);
		fault_count++;
	endtask

	// one channel of the blend between this hour and the next
	function automatic logic [CH_W-1:0] blend_channel(input int sel);
		int h;
		int lo;
		int hi;
		int s;
		h  = (clk_hour > HOURS_PER_DAY - 1) ? HOURS_PER_DAY - 1 : clk_hour;
		lo = int'(clk_colours[h][CH_W*sel +: CH_W]);
		hi = int'(clk_colours[h+1][CH_W*sel +: CH_W]);
		s  = lo + ((hi - lo) * clk_minute) / MINUTES_PER_HOUR;
		return s[CH_W-1:0];
	endfunction

	// apply one word to the clock and return the tint and time it reports
	function automatic tint_word_t next_tint(input clock_word_t w);
		tint_word_t r;
		int         minute_len;
		int         sum;
		int         h;
		int         m;
		case (w.operation)
			OP_TICK: begin
				if (day_len_set != 0) begin
					minute_len = ((day_len_set * DAY_SCALE) / HOURS_PER_DAY / MINUTES_PER_HOUR)
						<< ELAPSED_FRAC_BITS;
					sum = clk_acc + int'(w.elapsed);
					if (sum > ACC_FULL)
						sum = ACC_FULL;
					clk_acc = sum;
					if (sum > minute_len) begin
						clk_acc = 0;
						clk_minute++;
						if (clk_minute >= MINUTES_PER_HOUR) begin
							clk_minute = 0;
							clk_hour++;
							if (clk_hour >= HOURS_PER_DAY) begin
								clk_hour = 0;
								clk_days = clk_days + DAYS_W'(1);
							end
						end
					end
				end
			end
			OP_SET_TIME: begin
				h = int'(w.set_hour);
				m = int'(w.set_minute);
				if (h >= HOURS_PER_DAY)
					h -= HOURS_PER_DAY;
				if (m >= MINUTES_PER_HOUR)
					m = MINUTES_PER_HOUR - 1;
				clk_hour   = h;
				clk_minute = m;
				clk_days   = w.set_days;
				clk_acc    = 0;
			end
			OP_WRITE_ENTRY: begin
				if (w.entry_index < TABLE_ENTRIES)
					clk_colours[w.entry_index] = {w.entry_red, w.entry_green, w.entry_blue};
			end
			default: ;
		endcase
		r.red    = blend_channel(2);
		r.green  = blend_channel(1);
		r.blue   = blend_channel(0);
		r.hour   = clk_hour[HOUR_W-1:0];
		r.minute = clk_minute[MINUTE_W-1:0];
		r.days   = clk_days;
		return r;
	endfunction

	// random word: mostly ticks, with set-time words often near the end of a day
	function automatic clock_word_t random_word();
		clock_word_t      w;
		logic [95:0]      noise;
		int               pick;
		noise = {$urandom, $urandom, $urandom};
		w     = noise[$bits(clock_word_t)-1:0];
		pick  = $urandom_range(0, 99);
		if (pick < 62) begin
			w.operation = OP_TICK;
			if ($urandom_range(0, 3) != 0)
				w.elapsed = ELAPSED_W'($urandom_range(0, 4095));
		end else if (pick < 77) begin
			w.operation = OP_SET_TIME;
			if ($urandom_range(0, 2) == 0) begin
				w.set_hour   = 5'd23;
				w.set_minute = MINUTE_W'($urandom_range(56, 63));
			end
			if ($urandom_range(0, 3) == 0)
				w.set_days = 32'hFFFF_FFFF - $urandom_range(0, 1);
		end else if (pick < 95) begin
			w.operation = OP_WRITE_ENTRY;
		end else begin
			w.operation = OP_SPARE;
		end
		return w;
	endfunction

	// offer one word, wait for it to be taken, queue what it should give
	task automatic send_word(input clock_word_t w, input logic typed, input tint_word_t want);
		tint_word_t model;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_if.valid <= 1'b0;
			@(posedge clk);
		end
		item_if.operation   <= w.operation;
		item_if.elapsed     <= w.elapsed;
		item_if.set_hour    <= w.set_hour;
		item_if.set_minute  <= w.set_minute;
		item_if.set_days    <= w.set_days;
		item_if.entry_index <= w.entry_index;
		item_if.entry_red   <= w.entry_red;
		item_if.entry_green <= w.entry_green;
		item_if.entry_blue  <= w.entry_blue;
		item_if.valid       <= 1'b1;
		do
			@(posedge clk);
		while (!item_if.ready);
		model = next_tint(w);
		tint_due.push_back(typed ? want : model);
	endtask

	// stop offering and let every outstanding word come out
	task automatic settle();
		item_if.valid <= 1'b0;
		while (tint_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write of day_length, then read it back
	task automatic set_day_length(input logic [DAY_LEN_W-1:0] len);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= REG_DAY_LENGTH;
		pwdata  <= {{(PDATA_W-DAY_LEN_W){1'b0}}, len};
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		day_len_set = int'(len);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (prdata !== {{(PDATA_W-DAY_LEN_W){1'b0}}, len})
			report_fault($sformatf("day_length read exp %h act %h", len, prdata));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// receiver: random stalls, plus one long hold when asked
	initial begin
		int hold_left;
		hold_left     = 0;
		tint_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left     = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				tint_if.ready <= 1'b0;
			end else begin
				tint_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		tint_word_t seen;
		tint_word_t due;
		if (arst_n && tint_if.valid && tint_if.ready) begin
			seen = {tint_if.tint_red, tint_if.tint_green, tint_if.tint_blue,
				tint_if.hour_now, tint_if.minute_now, tint_if.days_passed};
			if (tint_due.size() == 0) begin
				report_fault($sformatf("unexpected result word %h", seen));
			end else begin
				due = tint_due.pop_front();
				if (seen.red !== due.red || seen.green !== due.green ||
					seen.blue !== due.blue || seen.hour !== due.hour ||
					seen.minute !== due.minute || seen.days !== due.days)
					report_fault($sformatf(
						"rgb exp %h%h%h act %h%h%h, time exp %0d:%0d d%0d act %0d:%0d d%0d",
						due.red, due.green, due.blue, seen.red, seen.green, seen.blue,
						due.hour, due.minute, due.days, seen.hour, seen.minute, seen.days));
			end
		end
	end

	// watchdog on cycles with no traffic at all
	always @(posedge clk) begin
		if (!arst_n || psel || (item_if.valid && item_if.ready) ||
			(tint_if.valid && tint_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_time_of_day_color_clock: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// stimulus
	initial begin
		logic [DAY_LEN_W-1:0] phase_len [PHASES];
		phase_len = '{16'hFFFF, 16'd0, 16'd1, 16'd900, 16'd14, 16'd0, 16'd15, 16'd0};
		phase_len[5] = DAY_LEN_W'($urandom_range(16, 65534));
		phase_len[7] = DAY_LEN_W'($urandom_range(16, 65534));

		arst_n              = 1'b0;
		psel                = 1'b0;
		penable             = 1'b0;
		pwrite              = 1'b0;
		paddr               = '0;
		pwdata              = '0;
		item_if.valid       = 1'b0;
		item_if.operation   = OP_TICK;
		item_if.elapsed     = '0;
		item_if.set_hour    = '0;
		item_if.set_minute  = '0;
		item_if.set_days    = '0;
		item_if.entry_index = '0;
		item_if.entry_red   = '0;
		item_if.entry_green = '0;
		item_if.entry_blue  = '0;

		day_len_set = RESET_DAY_LENGTH;
		clk_acc     = 0;
		clk_minute  = 0;
		clk_hour    = RESET_HOUR;
		clk_days    = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++)
			clk_colours[i] = DEFAULT_COLORS[i];

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// sender seldom idle, receiver stalling often
		send_idle_pct = 11;
		recv_idle_pct = 56;
		for (int i = 0; i < SCRIPT_ROWS; i++)
			send_word(SCRIPT[i].word, SCRIPT[i].typed, SCRIPT[i].want);

		for (int p = 0; p < PHASES; p++) begin
			settle();
			set_day_length(phase_len[p]);
			if (p < 3) begin
				send_idle_pct = 11;
				recv_idle_pct = 56;
			end else if (p < 6) begin
				send_idle_pct = 56;
				recv_idle_pct = 11;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			// back up the pipeline against a stalled output once
			if (p == 6)
				long_hold_req = 1'b1;
			repeat (PHASE_WORDS) send_word(random_word(), 1'b0, NO_TINT);
		end
		settle();

		if (fault_count == 0)
			$display("tb_time_of_day_color_clock: PASS");
		else
			$display("tb_time_of_day_color_clock: FAIL");
		$finish;
	end

endmodule

// File: time_of_day_color_clock.f
rtl/tdcc_pkg.sv
rtl/tdcc_item_if.sv
rtl/tdcc_tint_if.sv
rtl/time_of_day_color_clock.sv
tb/tb_time_of_day_color_clock.sv
